FILE: design/wsts_pkg.sv
// Package: shared constants, status codes and control structs of the scheduler.
package wsts_pkg;

    localparam int WORKERS_DEF   = 16;
    localparam int DEPTH_DEF     = 256;
    localparam int TASK_BITS_DEF = 16;

    localparam logic [2:0] ST_PUSHED = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_OWN    = 3'd2;
    localparam logic [2:0] ST_SAME   = 3'd3;
    localparam logic [2:0] ST_OTHER  = 3'd4;
    localparam logic [2:0] ST_NONE   = 3'd5;

    localparam logic [1:0] REG_WORKERS = 2'd0;
    localparam logic [1:0] REG_DOMAINS = 2'd1;
    localparam logic [1:0] REG_LIMIT   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input transaction
        logic eval;       // evaluate push or own pop
        logic norm;       // reduce own worker and victim pointer by subtraction
        logic scan_start; // take a start value from the victim pointer
        logic align;      // reduce the start candidate modulo domains
        logic scan_step;  // examine one candidate
        logic same_only;  // restrict the scan to the own domain
        logic rd_wait;    // memory read data available
        logic finish;     // latch the result
    } wsts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done_now;   // push or get from an invalid worker settled at eval
        logic own_read;   // own pop issued a memory read
        logic norm_done;  // own domain and victim pointer reduced
        logic align_done; // start candidate domain reduced
        logic hit;        // scan found a victim (read issued)
        logic scan_last;  // scan examined the last candidate
    } wsts_sts_t;

endpackage

FILE: design/wsts_ram.sv
// Generic single-port RAM with registered read.
module wsts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: design/wsts_ctrl.sv
// Controller state machine of the scheduler.
module wsts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_busy,
    input  wsts_pkg::wsts_sts_t sts,
    output wsts_pkg::wsts_cmd_t cmd,
    output logic              busy
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EVAL  = 9'b000000010,
        S_NORM  = 9'b000000100,
        S_START = 9'b000001000,
        S_ALIGN = 9'b000010000,
        S_SCAN  = 9'b000100000,
        S_READ  = 9'b001000000,
        S_DONE  = 9'b010000000,
        S_HOLD  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   same_reg, same_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            same_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            same_reg  <= same_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        same_next  = same_reg;
        cmd        = '0;
        cmd.same_only = same_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.own_read)
                begin
                    state_next = S_READ;
                end
                else if (sts.done_now)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    same_next  = 1'b1;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                cmd.norm = 1'b1;
                if (sts.norm_done)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_ALIGN;
            end
            S_ALIGN:
            begin
                cmd.align = 1'b1;
                if (sts.align_done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.hit)
                begin
                    state_next = S_READ;
                end
                else if (sts.scan_last)
                begin
                    if (same_reg)
                    begin
                        same_next  = 1'b0;
                        state_next = S_START;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_wait = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

FILE: design/wsts_dp.sv
// Datapath: deque pointers, victim scan and task memory of the scheduler.
module wsts_dp #(
    parameter int WORKERS   = wsts_pkg::WORKERS_DEF,
    parameter int DEPTH     = wsts_pkg::DEPTH_DEF,
    parameter int TASK_BITS = wsts_pkg::TASK_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wsts_pkg::wsts_cmd_t   cmd,
    output wsts_pkg::wsts_sts_t   sts,
    input  logic                  in_action,
    input  logic [3:0]            in_worker,
    input  logic [15:0]           in_task,
    input  logic [4:0]            cfg_workers,
    input  logic [4:0]            cfg_domains,
    input  logic [8:0]            cfg_limit,
    output logic [2:0]            res_status,
    output logic [15:0]           res_task,
    output logic [3:0]            res_src
);
    localparam int WB = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int DB = $clog2(DEPTH);
    localparam int CB = $clog2(DEPTH + 1);
    localparam int TB = (TASK_BITS < 16) ? TASK_BITS : 16;

    logic [DB-1:0] head_reg [WORKERS];
    logic [CB-1:0] fill_reg [WORKERS];
    logic [4:0]    vptr_reg;
    logic          act_reg;
    logic [3:0]    wk_reg;
    logic [15:0]   tin_reg;
    logic [4:0]    off_reg, vic_reg;
    logic [4:0]    wmod_reg;   // own worker mod domains, reduced by subtraction
    logic [4:0]    vmod_reg;   // candidate mod domains, tracked by stepping
    logic [2:0]    st_reg;
    logic [3:0]    src_reg;
    logic          from_mem_reg;
    logic [TB-1:0] task_reg;

    // Effective configuration.
    logic [4:0] wc, dc;
    logic [CB-1:0] lim;
    always_comb
    begin
        wc = (cfg_workers == 5'd0) ? 5'd1 : cfg_workers;
        if (32'(wc) > WORKERS)
        begin
            wc = 5'(WORKERS);
        end
        dc = (cfg_domains == 5'd0) ? 5'd1 : cfg_domains;
        lim = (32'(cfg_limit) > DEPTH) ? CB'(DEPTH) : CB'(cfg_limit);
    end

    logic [WB-1:0] wi, vi;
    assign wi = WB'(wk_reg);
    assign vi = WB'(vic_reg);

    logic valid_w;
    assign valid_w = ({1'b0, wk_reg} < wc) && (32'(wk_reg) < WORKERS);

    logic [CB-1:0] wfill, vfill;
    assign wfill = fill_reg[wi];
    assign vfill = fill_reg[vi];

    // Scan candidate checks.
    logic cand_ok;
    assign cand_ok = (vic_reg != {1'b0, wk_reg}) && (!cmd.same_only || vmod_reg == wmod_reg)
                     && (vfill != '0);
    assign sts.done_now   = !act_reg || !valid_w;
    assign sts.own_read   = act_reg && valid_w && (wfill != '0);
    assign sts.norm_done  = (wmod_reg < dc) && (vptr_reg < wc);
    assign sts.align_done = (vmod_reg < dc);
    assign sts.hit        = cand_ok;
    assign sts.scan_last  = (off_reg + 5'd1 >= wc);

    // Memory port.
    localparam int AB = $clog2(WORKERS * DEPTH);
    logic [AB-1:0] addr;
    logic          we;
    logic [TB-1:0] rdata;
    logic [DB-1:0] pos;

    always_comb
    begin
        we   = 1'b0;
        pos  = head_reg[wi] + DB'(wfill);
        addr = AB'({wi, pos});
        if (cmd.eval && act_reg)
        begin
            pos  = head_reg[wi] + DB'(wfill) - DB'(1);
            addr = AB'({wi, pos});
        end
        else if (cmd.eval)
        begin
            we = valid_w && (wfill < lim);
        end
        else if (cmd.scan_step)
        begin
            addr = AB'({vi, head_reg[vi]});
        end
    end

    wsts_ram #(.WIDTH(TB), .DEPTH(WORKERS * DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (tin_reg[TB-1:0]),
        .rdata (rdata)
    );

    // Deque pointers and victim pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORKERS; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            vptr_reg <= '0;
        end
        else
        begin
            if (cmd.eval && we)
            begin
                fill_reg[wi] <= wfill + CB'(1);
            end
            if (cmd.eval && sts.own_read)
            begin
                fill_reg[wi] <= wfill - CB'(1);
            end
            // Bring the pointer below the worker count one subtraction at a time.
            if (cmd.norm && vptr_reg >= wc)
            begin
                vptr_reg <= vptr_reg - wc;
            end
            if (cmd.scan_start)
            begin
                vptr_reg <= (vptr_reg + 5'd1 >= wc) ? 5'd0 : vptr_reg + 5'd1;
            end
            if (cmd.scan_step && cand_ok)
            begin
                fill_reg[vi] <= vfill - CB'(1);
                head_reg[vi] <= head_reg[vi] + DB'(1);
            end
        end
    end

    // Transaction capture, scan walk and result.
    logic [4:0] vnext;
    assign vnext = (vic_reg + 5'd1 >= wc) ? 5'd0 : vic_reg + 5'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= in_action;
            wk_reg  <= in_worker;
            tin_reg <= in_task;
        end
        if (cmd.eval)
        begin
            wmod_reg     <= {1'b0, wk_reg};
            from_mem_reg <= sts.own_read;
            src_reg      <= sts.own_read || !act_reg ? wk_reg : 4'd0;
            if (!act_reg)
            begin
                st_reg <= we ? wsts_pkg::ST_PUSHED : wsts_pkg::ST_FULL;
            end
            else if (sts.own_read)
            begin
                st_reg <= wsts_pkg::ST_OWN;
            end
            else
            begin
                st_reg <= wsts_pkg::ST_NONE;
            end
        end
        if (cmd.norm && wmod_reg >= dc)
        begin
            wmod_reg <= wmod_reg - dc;
        end
        if (cmd.scan_start)
        begin
            vic_reg  <= vptr_reg;
            vmod_reg <= vptr_reg;
            off_reg  <= '0;
        end
        if (cmd.align && vmod_reg >= dc)
        begin
            vmod_reg <= vmod_reg - dc;
        end
        if (cmd.scan_step)
        begin
            if (cand_ok)
            begin
                from_mem_reg <= 1'b1;
                src_reg      <= vic_reg[3:0];
                st_reg       <= cmd.same_only ? wsts_pkg::ST_SAME : wsts_pkg::ST_OTHER;
            end
            vic_reg  <= vnext;
            vmod_reg <= (vnext == 5'd0) ? 5'd0 :
                        ((vmod_reg + 5'd1 >= dc) ? 5'd0 : vmod_reg + 5'd1);
            off_reg  <= off_reg + 5'd1;
        end
        // Hold the read data; the memory output moves on with the address.
        if (cmd.rd_wait)
        begin
            task_reg <= rdata;
        end
        if (cmd.finish)
        begin
            res_status <= st_reg;
            res_src    <= src_reg;
            res_task   <= from_mem_reg ? 16'(task_reg) : 16'd0;
        end
    end
endmodule

FILE: design/work_stealing_task_scheduler_unit.sv
// Top level of the work-stealing task scheduler.
//
//  channel | direction | handshake          | payload
//  input   | in        | in_valid/in_stall  | action, worker, task_in
//  output  | out       | out_valid/out_stall| status, task_out, source_worker
//  config  | in        | APB write/read     | worker_count, domain_count, queue_limit
//
// A push, full push or get from an inactive worker passes EVAL to DONE after
// acceptance, an own pop passes READ on the way; the block returns to IDLE before
// the next acceptance. A steal first reduces the own domain and victim pointer by
// repeated subtraction, then per pass takes a start step, reduces the start domain
// by subtraction and scans up to worker_count candidates; a hit adds a read step.
// One transaction is in flight at a time; in_stall is high while it is.
// Reset clears all deque pointers at once; the task memory needs no pass.
// A held result stalls completion; the next transaction waits for it.
module work_stealing_task_scheduler_unit #(
    parameter int WORKERS   = wsts_pkg::WORKERS_DEF,
    parameter int DEPTH     = wsts_pkg::DEPTH_DEF,
    parameter int TASK_BITS = wsts_pkg::TASK_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [3:0]  worker,
    input  logic [15:0] task_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] task_out,
    output logic [3:0]  source_worker,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    wsts_pkg::wsts_cmd_t cmd;
    wsts_pkg::wsts_sts_t sts;
    logic busy, in_fire;
    logic out_valid_reg;

    logic [4:0] wc_reg, dc_reg;
    logic [8:0] lim_reg;

    // Configuration registers: write on the access phase.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg  <= 5'd16;
            dc_reg  <= 5'd1;
            lim_reg <= 9'd256;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                wsts_pkg::REG_WORKERS: wc_reg  <= pwdata[4:0];
                wsts_pkg::REG_DOMAINS: dc_reg  <= pwdata[4:0];
                wsts_pkg::REG_LIMIT:   lim_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            wsts_pkg::REG_WORKERS: prdata = {27'd0, wc_reg};
            wsts_pkg::REG_DOMAINS: prdata = {27'd0, dc_reg};
            wsts_pkg::REG_LIMIT:   prdata = {23'd0, lim_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // Accept only when idle; hold the result until taken.
    assign in_stall = busy;
    assign in_fire  = in_valid && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end
    assign out_valid = out_valid_reg;

    wsts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (out_valid_reg && out_stall),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    wsts_dp #(.WORKERS(WORKERS), .DEPTH(DEPTH), .TASK_BITS(TASK_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_action   (action),
        .in_worker   (worker),
        .in_task     (task_in),
        .cfg_workers (wc_reg),
        .cfg_domains (dc_reg),
        .cfg_limit   (lim_reg),
        .res_status  (status),
        .res_task    (task_out),
        .res_src     (source_worker)
    );
endmodule

FILE: sim/wsts_checker.sv
// Checker: watches the scheduler channels, predicts each result and compares it.
module wsts_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        action,
    input  logic [3:0]  worker,
    input  logic [15:0] task_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [15:0] task_out,
    input  logic [3:0]  source_worker,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] task_id;
        logic [3:0]  source;
    } grant_t;

    localparam int DUE_SLOTS = 64;

    logic [15:0] deque_mem [16][256];
    logic [7:0]  head [16];
    logic [8:0]  fill [16];
    logic [3:0]  victim_ptr;
    logic [4:0]  cfg_workers;
    logic [4:0]  cfg_domains;
    logic [8:0]  cfg_limit;
    grant_t      grants_due [DUE_SLOTS];
    int          due_rd;
    int          due_wr;

    function automatic int live_workers();
        if (cfg_workers == 0) return 1;
        if (cfg_workers > 16) return 16;
        return cfg_workers;
    endfunction

    // Walk the other workers from the victim pointer; steal from the first front.
    function automatic bit steal_scan(int w, bit same_only, output grant_t g);
        int wc;
        int dc;
        int start;
        int v;
        wc = live_workers();
        dc = (cfg_domains == 0) ? 1 : cfg_domains;
        start = victim_ptr % wc;
        victim_ptr = 4'((start + 1) % wc);
        for (int off = 0; off < wc; off++)
        begin
            v = (start + off) % wc;
            if (v == w) continue;
            if (same_only && (v % dc) != (w % dc)) continue;
            if (fill[v] != 0)
            begin
                g.task_id = deque_mem[v][head[v]];
                head[v] = head[v] + 8'd1;
                fill[v] = fill[v] - 9'd1;
                g.source = v[3:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic grant_t schedule(logic act, logic [3:0] w, logic [15:0] tid);
        grant_t g;
        int lim;
        bit live;
        logic [7:0] pos;
        g = '0;
        lim = (cfg_limit > 256) ? 256 : cfg_limit;
        live = w < live_workers();
        if (act == 1'b0)
        begin
            g.source = w;
            if (!live || fill[w] >= lim)
                g.status = wsts_pkg::ST_FULL;
            else
            begin
                pos = head[w] + fill[w][7:0];
                deque_mem[w][pos] = tid;
                fill[w] = fill[w] + 9'd1;
                g.status = wsts_pkg::ST_PUSHED;
            end
        end
        else if (!live)
            g.status = wsts_pkg::ST_NONE;
        else if (fill[w] != 0)
        begin
            pos = head[w] + fill[w][7:0] - 8'd1;
            fill[w] = fill[w] - 9'd1;
            g.task_id = deque_mem[w][pos];
            g.source = w;
            g.status = wsts_pkg::ST_OWN;
        end
        else if (steal_scan(w, 1'b1, g))
            g.status = wsts_pkg::ST_SAME;
        else if (steal_scan(w, 1'b0, g))
            g.status = wsts_pkg::ST_OTHER;
        else
        begin
            g = '0;
            g.status = wsts_pkg::ST_NONE;
        end
        return g;
    endfunction

    task automatic report(string field, int got, int want);
        $display("%0t ns: %s got %0d, want %0d", $time, field, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                head[i] = '0;
                fill[i] = '0;
            end
            victim_ptr = '0;
            cfg_workers = 5'd16;
            cfg_domains = 5'd1;
            cfg_limit = 9'd256;
            due_rd = 0;
            due_wr = 0;
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    wsts_pkg::REG_WORKERS: cfg_workers = pwdata[4:0];
                    wsts_pkg::REG_DOMAINS: cfg_domains = pwdata[4:0];
                    wsts_pkg::REG_LIMIT:   cfg_limit = pwdata[8:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (due_wr == due_rd)
                    report("unexpected result, status", status, -1);
                else
                begin
                    want = grants_due[due_rd % DUE_SLOTS];
                    due_rd++;
                    if (status !== want.status)
                        report("status", status, want.status);
                    if (task_out !== want.task_id)
                        report("task_out", task_out, want.task_id);
                    if (source_worker !== want.source)
                        report("source_worker", source_worker, want.source);
                end
            end
            if (in_valid && !in_stall)
            begin
                grants_due[due_wr % DUE_SLOTS] = schedule(action, worker, task_in);
                due_wr++;
            end
            pending = due_wr - due_rd;
        end
    end
endmodule

FILE: sim/tb_top.sv
// Testbench top: drives stimulus and configuration into the scheduler and gives the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = 1'b0;
    logic [3:0]  worker = '0;
    logic [15:0] task_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [15:0] task_out;
    logic [3:0]  source_worker;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    bit          calm = 1'b0;   // no idling on either side while set
    int          stall_left = 0;

    // Settle time after the last result is taken; the block is idle by then.
    localparam int DRAIN_CYCLES = 2 * 16 + 10;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    work_stealing_task_scheduler_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .worker(worker), .task_in(task_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .task_out(task_out), .source_worker(source_worker),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    wsts_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .worker(worker), .task_in(task_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .task_out(task_out), .source_worker(source_worker),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .errors(errors), .pending(pending)
    );

    // Receiver: after each accepted result, hold stall for a drawn number of cycles.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            stall_left = calm ? 0 : $urandom_range(0, 7);
        else if (stall_left > 0)
            stall_left = stall_left - 1;
        out_stall <= (stall_left > 0);
    end

    // Offer one transaction after a drawn gap and hold it until accepted.
    task automatic send(logic act, logic [3:0] w, logic [15:0] tid);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        worker <= w;
        task_in <= tid;
        do @(posedge clk); while (in_stall);
    endtask

    // Drain all results, let the block settle, then write one register.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(int wc, int dc, int ql);
        write_reg(wsts_pkg::REG_WORKERS, wc);
        write_reg(wsts_pkg::REG_DOMAINS, dc);
        write_reg(wsts_pkg::REG_LIMIT, ql);
    endtask

    initial
    begin
        int wc_set [7] = '{16, 1, 16, 5, 0, 31, 8};
        int dc_set [7] = '{1, 1, 16, 3, 0, 2, 4};
        int ql_set [7] = '{256, 1, 4, 8, 0, 300, 3};
        logic act;
        logic [3:0] w;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fill to the limit, own pop, steals across domains, idle gets
        set_config(4, 2, 2);
        send(1'b0, 4'd0, 16'hFFFF);
        send(1'b0, 4'd0, 16'h0000);
        send(1'b0, 4'd0, 16'h1234);  // deque at limit
        send(1'b1, 4'd0, 16'h0000);  // own pop from the back
        send(1'b1, 4'd1, 16'hFFFF);  // nothing in own domain: steal from worker 0
        send(1'b0, 4'd2, 16'hAAAA);
        send(1'b1, 4'd0, 16'h5555);  // steal within the domain
        send(1'b1, 4'd1, 16'h0000);  // nothing anywhere
        send(1'b0, 4'd5, 16'h7777);  // worker beyond the active count
        send(1'b1, 4'd15, 16'h0000);
        send(1'b0, 4'd3, 16'h8001);
        send(1'b1, 4'd3, 16'h0000);

        // Random phases over several settings, some run without idling
        for (int ph = 0; ph < 7; ph++)
        begin
            set_config(wc_set[ph], dc_set[ph], ql_set[ph]);
            calm = (ph % 3 == 2);
            for (int n = 0; n < 277; n++)
            begin
                act = ($urandom_range(0, 99) < 52) ? 1'b0 : 1'b1;
                // favour active workers but keep some outside the count
                if ($urandom_range(0, 9) < 8 && wc_set[ph] > 0)
                    w = 4'($urandom_range(0, (wc_set[ph] > 16 ? 16 : wc_set[ph]) - 1));
                else
                    w = 4'($urandom_range(0, 15));
                send(act, w, 16'($urandom_range(0, 16'hFFFF)));
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("work_stealing_task_scheduler_unit: match");
        else
            $display("work_stealing_task_scheduler_unit: mismatch");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("work_stealing_task_scheduler_unit: mismatch");
        $finish;
    end
endmodule
